@@ rtl/bbu_pkg.sv @@
// Shared types, codes and helpers of the background update block.
// No dependencies; every other file imports it.
package bbu_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_W     = 9;   // widest register: threshold
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 12;  // nine 8-bit channels summed

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

  localparam logic [1:0] ACT_KEPT     = 2'd0;
  localparam logic [1:0] ACT_REPLACED = 2'd1;
  localparam logic [1:0] ACT_MEAN     = 2'd2;

  typedef struct packed {
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;
    logic       cur_present;
    logic       fg_masked;
  } in_t;

  typedef struct packed {
    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic [7:0]  bg_red;
    logic [7:0]  bg_green;
    logic [7:0]  bg_blue;
    logic [1:0]  action;
    logic        frame_last;
    logic [11:0] replaced_total;
  } out_t;

  typedef struct packed {
    logic accept;
    logic classify;
    logic nbr;
    logic replace;
    logic keep;
    logic div_start;
    logic mean;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic has_result;
    logic nbr_done;
    logic center_valid;
    logic cnt_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

@@ rtl/block_background_update.sv @@
// Top level of the background update block: controller plus datapath.
// Depends on bbu_pkg, bbu_ctrl, bbu_datapath.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_stall     in_data   (in_t)
//  out      output     out_valid / out_stall   out_data  (out_t)
//  cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// A cell that yields no result passes through accept and classify. A cell that
// yields a result adds a scan of its 3x3 window (one line-buffer read per
// cycle), a decision state and, for a neighbor mean, a run of the bit-serial
// divider. The output register is then loaded once it is free.
// After reset the background memory is zeroed, one entry per cycle:
// MAX_HEIGHT*MAX_WIDTH entries (4096 by default), with in_stall high.
// A held result in the output register does not block the next transfer in;
// only the following emit waits on out_stall.
module block_background_update import bbu_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one cell in flight at a time
  bbu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, arithmetic and output register
  bbu_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/bbu_div.sv @@
// Three-channel restoring divider, one quotient bit per cycle.
// Depends on bbu_pkg.
module bbu_div import bbu_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [3:0]                  divisor,
  input  logic [2:0][SUM_W-1:0]       dividend,
  output logic                        done,
  output logic [2:0][7:0]             quot
);

  localparam int STW = $clog2(SUM_W);
  localparam logic [STW-1:0] LAST = STW'(SUM_W - 1);

  logic                  busy_r, done_r;
  logic [STW-1:0]        step_r;
  logic [3:0]            dsr_r;
  logic [2:0][4:0]       rem_r, rem_nxt;
  logic [2:0][SUM_W-1:0] dvd_r, dvd_nxt;

  always_comb begin
    logic [4:0] sh;
    logic       qb;
    for (int c = 0; c < 3; c++) begin
      sh = {rem_r[c][3:0], dvd_r[c][SUM_W-1]};
      qb = (sh >= {1'b0, dsr_r});
      rem_nxt[c] = qb ? sh - {1'b0, dsr_r} : sh;
      dvd_nxt[c] = {dvd_r[c][SUM_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 3; c++) quot[c] = dvd_r[c][7:0];
  end

endmodule

@@ rtl/bbu_datapath.sv @@
// Datapath: config, position counters, background and line memories,
// neighbor accumulation, divider and output register. Depends on bbu_pkg, bbu_div.
module bbu_datapath import bbu_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int RAW = $clog2(MAX_HEIGHT);

  // config
  logic [8:0] thr_r;
  logic [6:0] gw_r, gh_r;
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 9'd16;
      gw_r  <= 7'd64;
      gh_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:   thr_r <= cfg_wdata;
        CFG_GRID_WIDTH:  gw_r  <= cfg_wdata[6:0];
        CFG_GRID_HEIGHT: gh_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gw_r < 7'd3)               w_eff = CW'(3);
    else if (int'(gw_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else                           w_eff = CW'(gw_r);
    if (gh_r < 7'd3)                 h_eff = RW'(3);
    else if (int'(gh_r) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else                             h_eff = RW'(gh_r);
  end

  // position counters; slot tracks row mod 3
  logic [CW-1:0] col_r, j0, jn, j_r;
  logic [RW-1:0] row_r, i0, rn, i_r;
  logic [1:0]    slot_r, s0, sn, s_r;
  logic          intr_r, res_r, last_r;
  logic [11:0]   rep_r;
  in_t           pix_r;

  always_comb begin
    j0 = col_r; i0 = row_r; s0 = slot_r;
    if (j0 >= w_eff) begin
      j0 = '0; i0 = i0 + 1'b1; s0 = slot_inc(s0);
    end
    if (i0 >= h_eff) begin
      i0 = '0; s0 = 2'd0;
    end
    jn = j0 + 1'b1; rn = i0; sn = s0;
    if (jn >= w_eff) begin
      jn = '0; rn = i0 + 1'b1; sn = slot_inc(s0);
      if (rn >= h_eff) begin
        rn = '0; sn = 2'd0;
      end
    end
  end

  // neighbor read sequencing
  logic [1:0]  kr_r, kn_r;
  logic        iss_done_r, rd_vld_r, ctr_pend_r;
  logic [24:0] line_rd_r, center_r;
  logic [3:0]  cnt_r;
  logic [2:0][SUM_W-1:0] sum_r;
  logic        nbr_iss;
  assign nbr_iss = cmd.nbr && !iss_done_r;

  // background memory ports
  logic [23:0] bg_mem [MAX_HEIGHT][MAX_WIDTH];
  logic [23:0] bg_rd_r, bg_wd;
  logic        bg_re, bg_we;
  logic [RAW-1:0] bg_rr, bg_wr, clr_row_r;
  logic [CAW-1:0] bg_rc, bg_wc, clr_col_r;
  logic [RW-1:0]  cr;
  logic [CW-1:0]  cc;
  logic [2:0][7:0] quot;
  logic            div_done;

  assign cr = i_r - 1'b1;
  assign cc = j_r - 1'b1;

  assign bg_re = cmd.accept || cmd.classify;
  assign bg_rr = cmd.accept ? i0[RAW-1:0] : cr[RAW-1:0];
  assign bg_rc = cmd.accept ? j0[CAW-1:0] : cc[CAW-1:0];
  assign bg_we = cmd.clear || cmd.replace || cmd.mean;
  assign bg_wr = cmd.clear ? clr_row_r : cr[RAW-1:0];
  assign bg_wc = cmd.clear ? clr_col_r : cc[CAW-1:0];

  always_comb begin
    priority if (cmd.clear)   bg_wd = '0;
    else if (cmd.replace)     bg_wd = center_r[23:0];
    else                      bg_wd = {quot[2], quot[1], quot[0]};
  end

  always_ff @(posedge clk) begin
    if (bg_re) bg_rd_r <= bg_mem[bg_rr][bg_rc];
  end

  always_ff @(posedge clk) begin
    if (bg_we) bg_mem[bg_wr][bg_wc] <= bg_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
      clr_col_r <= '0;
    end else if (cmd.clear) begin
      if (clr_col_r == CAW'(MAX_WIDTH - 1)) begin
        clr_col_r <= '0;
        clr_row_r <= clr_row_r + 1'b1;
      end else begin
        clr_col_r <= clr_col_r + 1'b1;
      end
    end
  end

  // classification of the arriving cell
  logic [7:0] dr, dg, db, dmax;
  logic       cell_valid;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    dr = absdiff(pix_r.cur_red,   bg_rd_r[23:16]);
    dg = absdiff(pix_r.cur_green, bg_rd_r[15:8]);
    db = absdiff(pix_r.cur_blue,  bg_rd_r[7:0]);
    dmax = dr;
    if (dg > dmax) dmax = dg;
    if (db > dmax) dmax = db;
    if (intr_r)
      cell_valid = pix_r.cur_present && !pix_r.fg_masked && ({1'b0, dmax} < thr_r);
    else
      cell_valid = pix_r.cur_present;
  end

  // line memory: three rows of {valid, rgb}
  logic [24:0] line_mem [3][MAX_WIDTH];
  logic [1:0]  rd_slot;
  logic [CW-1:0] rd_col;

  always_comb begin
    unique case (kr_r)
      2'd0:    rd_slot = slot_dec(slot_dec(s_r));
      2'd1:    rd_slot = slot_dec(s_r);
      default: rd_slot = s_r;
    endcase
    rd_col = j_r - CW'(2) + CW'(kn_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.classify)
      line_mem[s_r][j_r[CAW-1:0]] <= {cell_valid, pix_r.cur_red, pix_r.cur_green,
                                      pix_r.cur_blue};
    if (nbr_iss) line_rd_r <= line_mem[rd_slot][rd_col[CAW-1:0]];
  end

  // counters, flags and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; slot_r <= 2'd0;
      i_r <= '0; j_r <= '0; s_r <= 2'd0;
      intr_r <= 1'b0; res_r <= 1'b0; last_r <= 1'b0;
      rep_r <= '0;
      kr_r <= '0; kn_r <= '0;
      iss_done_r <= 1'b0; rd_vld_r <= 1'b0; ctr_pend_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cmd.accept) begin
        col_r <= jn; row_r <= rn; slot_r <= sn;
        i_r <= i0; j_r <= j0; s_r <= s0;
        intr_r <= (i0 >= RW'(1)) && (i0 + 1'b1 < h_eff) &&
                  (j0 >= CW'(1)) && (j0 + 1'b1 < w_eff);
        res_r  <= (i0 >= RW'(2)) && (j0 >= CW'(2));
        last_r <= (i0 + 1'b1 == h_eff) && (j0 + 1'b1 == w_eff);
        if (i0 == '0 && j0 == '0) rep_r <= '0;
      end
      if (cmd.replace) rep_r <= rep_r + 1'b1;
      if (cmd.classify) begin
        kr_r <= '0; kn_r <= '0;
        iss_done_r <= 1'b0; rd_vld_r <= 1'b0; ctr_pend_r <= 1'b0;
        cnt_r <= '0;
      end else begin
        rd_vld_r   <= nbr_iss;
        ctr_pend_r <= nbr_iss && kr_r == 2'd1 && kn_r == 2'd1;
        if (nbr_iss) begin
          if (kn_r == 2'd2) begin
            kn_r <= '0;
            kr_r <= kr_r + 1'b1;
            if (kr_r == 2'd2) iss_done_r <= 1'b1;
          end else begin
            kn_r <= kn_r + 1'b1;
          end
        end
        if (rd_vld_r && line_rd_r[24]) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) pix_r <= in_data;
    if (cmd.classify) begin
      sum_r <= '0;
    end else if (rd_vld_r) begin
      if (line_rd_r[24])
        for (int c = 0; c < 3; c++)
          sum_r[c] <= sum_r[c] + SUM_W'(line_rd_r[c*8 +: 8]);
      if (ctr_pend_r) center_r <= line_rd_r;
    end
  end

  bbu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (cnt_r),
    .dividend (sum_r),
    .done     (div_done),
    .quot     (quot)
  );

  // result and output register
  logic [23:0] res_rgb_r;
  logic [1:0]  act_r;
  logic        out_valid_r;
  out_t        out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.replace) begin
      res_rgb_r <= center_r[23:0]; act_r <= ACT_REPLACED;
    end else if (cmd.keep) begin
      res_rgb_r <= bg_rd_r; act_r <= ACT_KEPT;
    end else if (cmd.mean) begin
      res_rgb_r <= {quot[2], quot[1], quot[0]}; act_r <= ACT_MEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.out_row        <= 6'(cr);
      out_data_r.out_col        <= 6'(cc);
      out_data_r.bg_red         <= res_rgb_r[23:16];
      out_data_r.bg_green       <= res_rgb_r[15:8];
      out_data_r.bg_blue        <= res_rgb_r[7:0];
      out_data_r.action         <= act_r;
      out_data_r.frame_last     <= last_r;
      out_data_r.replaced_total <= rep_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.clear_last   = (clr_row_r == RAW'(MAX_HEIGHT - 1)) &&
                       (clr_col_r == CAW'(MAX_WIDTH - 1));
    sts.has_result   = res_r;
    sts.nbr_done     = iss_done_r && !rd_vld_r;
    sts.center_valid = center_r[24];
    sts.cnt_zero     = (cnt_r == '0);
    sts.div_done     = div_done;
    sts.out_free     = !out_valid_r || !out_stall;
  end

endmodule

@@ rtl/bbu_ctrl.sv @@
// Controller FSM sequencing clear, accept, classify, neighbor scan, decision, divide and emit.
// Depends on bbu_pkg.
module bbu_ctrl import bbu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CLASS, S_NBR, S_DEC, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt = sts.has_result ? S_NBR : S_IDLE;
      end
      S_NBR: begin
        cmd.nbr = 1'b1;
        if (sts.nbr_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        priority if (sts.center_valid) begin
          cmd.replace = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.cnt_zero) begin
          cmd.keep = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.mean = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
